/* design/rfa_pkg.sv */
package rfa_pkg;

   localparam int unsigned DataWidth = 32;

   typedef enum logic [2:0] {
      FUNC_LOAD   = 3'd0,
      FUNC_ADD    = 3'd1,
      FUNC_SUB    = 3'd2,
      FUNC_MUL    = 3'd3,
      FUNC_DIV    = 3'd4,
      FUNC_INC    = 3'd5,
      FUNC_REDUCE = 3'd6,
      FUNC_NOP    = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LOAD_ZERO = 2'd1,
      STATUS_DIV_ZERO = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_SUM,
      ST_COMBINE,
      ST_GCD_INIT,
      ST_GCD_TWO,
      ST_GCD_ODD,
      ST_GCD_STEP,
      ST_GCD_SHIFT,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]           func;
      logic [DataWidth-1:0] operand_numerator;
      logic [DataWidth-1:0] operand_denominator;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result_numerator;
      logic [DataWidth-1:0] result_denominator;
      logic [1:0]           status;
   } rsp_type;

endpackage

/* design/rfa_divider.sv */
module rfa_divider #(
   parameter int unsigned W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient
);
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  quot_ff, quot_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[W-1:0], quot_ff[W-1]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, dividend shifted out of the quotient reg
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

   property p_count_tracks_busy;
      @(posedge clock) disable iff (reset) busy_ff |-> (cnt_ff != '0);
   endproperty
   a_count_tracks_busy: assert property (p_count_tracks_busy)
      else $error("divider busy with zero count");

   property p_start_busy;
      @(posedge clock) disable iff (reset) start |=> busy_ff;
   endproperty
   a_start_busy: assert property (p_start_busy)
      else $error("divider did not start");

   property p_remainder_bound;
      @(posedge clock) disable iff (reset) busy_ff |-> (rem_ff < {1'b0, dvs_ff});
   endproperty
   a_remainder_bound: assert property (p_remainder_bound)
      else $error("divider remainder out of range");

endmodule

/* design/rational_fraction_alu.sv */
// rational fraction accumulator with gcd reduction
// req channel: req_valid/req_ready, req_data carries func and operand fraction
// rsp channel: rsp_valid/rsp_ready, rsp_data carries accumulator and status
// one transfer on req gives exactly one transfer on rsp
// load, increment and no-op: decided in mul_a, then done raises rsp_valid
// multiply and divide: the products on one shared 32x32 multiplier, gcd setup,
// the binary gcd at one shift or subtract per cycle, two divisions
// on one shared restoring divider, then check and done
// add and subtract also pass through combine, reduce skips the multiplier states
// req_ready is high only in idle, from the cycle in which rsp_valid rises,
// so a new item is taken only once the last one has left done
// a stalled rsp holds its data until rsp_ready; the next item is worked
// meanwhile and waits in done until the held response is taken
// reset: accumulator 0/1, no response pending, ready in the first cycle
module rational_fraction_alu (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rfa_pkg::rsp_type rsp_data
);
   import rfa_pkg::*;

   localparam int unsigned WIDTH = DataWidth;
   localparam int unsigned W2 = 2 * WIDTH;
   localparam int unsigned SW = $clog2(W2 + 1);

   state_type state_ff, state_in;

   logic [WIDTH-1:0] accn_ff, accn_in, accd_ff, accd_in;
   func_type         func_ff, func_in;
   logic [WIDTH-1:0] opn_ff, opn_in, opd_ff, opd_in;
   logic [W2-1:0]    p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic             s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [W2:0]      nmag_ff, nmag_in, dmag_ff, dmag_in;
   logic             nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [W2:0]      ga_ff, ga_in, gb_ff, gb_in;
   logic [SW-1:0]    sh_ff, sh_in;
   logic [1:0]       stat_ff, stat_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [WIDTH-1:0] ma, mb;
   logic [W2-1:0]    prod_ff;
   logic             div_start, div_busy;
   logic [W2:0]      div_a, div_b, div_q;
   logic [WIDTH-1:0] an_mag, ad_mag, on_mag, od_mag;
   logic             an_neg, ad_neg, on_neg, od_neg;
   logic [W2:0]      sum_mag;
   logic             sum_neg;
   logic [W2:0]      pos_lim, neg_lim;
   logic             fit_n, fit_d;
   logic [WIDTH:0]   inc_sum;

   function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
      mag_of = v[WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign an_neg = accn_ff[WIDTH-1];
   assign ad_neg = accd_ff[WIDTH-1];
   assign on_neg = opn_ff[WIDTH-1];
   assign od_neg = opd_ff[WIDTH-1];
   assign an_mag = mag_of(accn_ff);
   assign ad_mag = mag_of(accd_ff);
   assign on_mag = mag_of(opn_ff);
   assign od_mag = mag_of(opd_ff);

   // shared multiplier operand select
   always_comb begin
      ma = an_mag;
      mb = od_mag;
      unique case (state_ff)
         ST_MUL_A: begin
            ma = an_mag;
            mb = (func_ff == FUNC_MUL) ? on_mag : od_mag;
         end
         ST_MUL_B: begin
            ma = ad_mag;
            mb = (func_ff == FUNC_DIV) ? on_mag : od_mag;
         end
         ST_MUL_C: begin
            ma = on_mag;
            mb = ad_mag;
         end
         default: begin
            ma = an_mag;
            mb = od_mag;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= W2'(ma) * W2'(mb);
   end

   rfa_divider #(.W(W2 + 1)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // signed add of two sign/magnitude products
   always_comb begin
      if (s0_ff == s2_ff) begin
         sum_mag = {1'b0, p0_ff} + {1'b0, p2_ff};
         sum_neg = s0_ff;
      end else if (p0_ff >= p2_ff) begin
         sum_mag = {1'b0, p0_ff - p2_ff};
         sum_neg = s0_ff;
      end else begin
         sum_mag = {1'b0, p2_ff - p0_ff};
         sum_neg = s2_ff;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   assign pos_lim = (W2 + 1)'({1'b0, {(WIDTH - 1){1'b1}}});
   assign neg_lim = pos_lim + 1'b1;
   assign fit_n = nneg_ff ? (nmag_ff <= neg_lim) : (nmag_ff <= pos_lim);
   assign fit_d = dneg_ff ? (dmag_ff <= neg_lim) : (dmag_ff <= pos_lim);
   assign inc_sum = {accn_ff[WIDTH-1], accn_ff} + {accd_ff[WIDTH-1], accd_ff};

   always_comb begin
      state_in     = state_ff;
      accn_in      = accn_ff;
      accd_in      = accd_ff;
      func_in      = func_ff;
      opn_in       = opn_ff;
      opd_in       = opd_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      nmag_in      = nmag_ff;
      dmag_in      = dmag_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      sh_in        = sh_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      div_a        = nmag_ff;
      div_b        = ga_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = func_type'(req_data.func);
               opn_in  = WIDTH'(req_data.operand_numerator);
               opd_in  = WIDTH'(req_data.operand_denominator);
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            stat_in = STATUS_OK;
            unique case (func_ff)
               FUNC_LOAD: begin
                  accn_in = opn_ff;
                  if (opd_ff == '0) begin
                     accd_in = WIDTH'(1);
                     stat_in = STATUS_LOAD_ZERO;
                  end else begin
                     accd_in = opd_ff;
                  end
                  state_in = ST_DONE;
               end
               FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
                  if (opd_ff == '0 || (func_ff == FUNC_DIV && opn_ff == '0)) begin
                     stat_in  = STATUS_DIV_ZERO;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_MUL_B;
                  end
               end
               FUNC_INC: begin
                  if (inc_sum[WIDTH] != inc_sum[WIDTH-1]) stat_in = STATUS_OVERFLOW;
                  else accn_in = inc_sum[WIDTH-1:0];
                  state_in = ST_DONE;
               end
               FUNC_REDUCE: begin
                  nmag_in  = (W2 + 1)'(an_mag);
                  nneg_in  = an_neg;
                  dmag_in  = (W2 + 1)'(ad_mag);
                  dneg_in  = ad_neg;
                  state_in = ST_GCD_INIT;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL_B: begin
            // product of first pair available
            p0_in = prod_ff;
            s0_in = (func_ff == FUNC_MUL) ? (an_neg ^ on_neg) : (an_neg ^ od_neg);
            if (prod_ff == '0) s0_in = 1'b0;
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            p1_in = prod_ff;
            s1_in = (func_ff == FUNC_DIV) ? (ad_neg ^ on_neg) : (ad_neg ^ od_neg);
            if (prod_ff == '0) s1_in = 1'b0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            p2_in = prod_ff;
            s2_in = on_neg ^ ad_neg;
            if (prod_ff == '0) s2_in = 1'b0;
            else if (func_ff == FUNC_SUB) s2_in = ~(on_neg ^ ad_neg);
            if (func_ff == FUNC_ADD || func_ff == FUNC_SUB) begin
               state_in = ST_COMBINE;
            end else begin
               nmag_in  = {1'b0, p0_ff};
               nneg_in  = s0_ff;
               state_in = ST_GCD_INIT;
            end
            dmag_in = {1'b0, p1_ff};
            dneg_in = s1_ff;
         end
         ST_COMBINE: begin
            nmag_in  = sum_mag;
            nneg_in  = sum_neg;
            state_in = ST_GCD_INIT;
         end
         ST_GCD_INIT: begin
            ga_in = nmag_ff;
            gb_in = dmag_ff;
            sh_in = '0;
            if (nmag_ff == '0) begin
               ga_in    = dmag_ff;
               state_in = ST_GCD_SHIFT;
            end else if (dmag_ff == '0) begin
               state_in = ST_GCD_SHIFT;
            end else begin
               state_in = ST_GCD_TWO;
            end
         end
         ST_GCD_TWO: begin
            if (ga_ff[0] == 1'b0 && gb_ff[0] == 1'b0) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               sh_in = sh_ff + 1'b1;
            end else begin
               state_in = ST_GCD_ODD;
            end
         end
         ST_GCD_ODD: begin
            if (ga_ff[0] == 1'b0) ga_in = ga_ff >> 1;
            else state_in = ST_GCD_STEP;
         end
         ST_GCD_STEP: begin
            if (gb_ff[0] == 1'b0) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               gb_in = ga_ff - gb_ff;
               ga_in = gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
               if (gb_ff == ga_ff) state_in = ST_GCD_SHIFT;
            end
         end
         ST_GCD_SHIFT: begin
            if (sh_ff != '0) begin
               ga_in = ga_ff << 1;
               sh_in = sh_ff - 1'b1;
            end else begin
               if (ga_ff == '0) ga_in = (W2 + 1)'(1);
               div_start = 1'b1;
               div_a     = nmag_ff;
               div_b     = (ga_ff == '0) ? (W2 + 1)'(1) : ga_ff;
               state_in  = ST_DIV_NUM;
            end
         end
         ST_DIV_NUM: begin
            if (!div_busy) begin
               nmag_in   = div_q;
               div_start = 1'b1;
               div_a     = dmag_ff;
               div_b     = ga_ff;
               state_in  = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            if (!div_busy) begin
               dmag_in = div_q;
               if (nmag_ff == '0) nneg_in = 1'b0;
               stat_in  = STATUS_OK;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fit_n && fit_d) begin
               accn_in = nneg_ff ? WIDTH'(~nmag_ff + 1'b1) : WIDTH'(nmag_ff);
               accd_in = dneg_ff ? WIDTH'(~dmag_ff + 1'b1) : WIDTH'(dmag_ff);
            end else begin
               stat_in = STATUS_OVERFLOW;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_DONE && !rsp_valid_ff) rsp_valid_in = 1'b1;
   end

   logic [WIDTH-1:0] rn_ff, rd_ff;
   logic [1:0]       rs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accn_ff      <= '0;
         accd_ff      <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accn_ff      <= accn_in;
         accd_ff      <= accd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      opn_ff  <= opn_in;
      opd_ff  <= opd_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      s0_ff   <= s0_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      sh_ff   <= (state_ff == ST_IDLE) ? '0 : sh_in;
      stat_ff <= (state_ff == ST_IDLE) ? 2'(STATUS_OK) : stat_in;
      if (state_ff == ST_DONE && !rsp_valid_ff) begin
         rn_ff <= accn_ff;
         rd_ff <= accd_ff;
         rs_ff <= stat_ff;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_data.result_numerator   = rn_ff;
   assign rsp_data.result_denominator = rd_ff;
   assign rsp_data.status             = rs_ff;

   property p_ready_idle;
      @(posedge clock) disable iff (reset) req_ready |-> (state_ff == ST_IDLE);
   endproperty
   a_ready_idle: assert property (p_ready_idle)
      else $error("ready outside idle");

   property p_accept_leaves_idle;
      @(posedge clock) disable iff (reset) (req_valid && req_ready) |=> (state_ff == ST_MUL_A);
   endproperty
   a_accept_leaves_idle: assert property (p_accept_leaves_idle)
      else $error("transfer not started");

   property p_den_nonzero;
      @(posedge clock) disable iff (reset) (state_ff == ST_IDLE) |-> (accd_ff != '0);
   endproperty
   a_den_nonzero: assert property (p_den_nonzero)
      else $error("zero denominator stored");

endmodule

/* test/tb_rational_fraction_alu.sv */
`timescale 1ns / 1ps

module tb_rational_fraction_alu;
   import rfa_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rational_fraction_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      func_type    func;
      logic [31:0] num;
      logic [31:0] den;
      bit          known;
      rsp_type     want;
   } stim_row_type;

   logic signed [31:0] acc_num = 32'sd0;
   logic signed [31:0] acc_den = 32'sd1;
   rsp_type            pending_fractions[$];
   int                 error_count = 0;
   int                 sent_count = 0;
   int                 tx_idle_pct = 15;
   int                 rx_idle_pct = 50;
   bit                 rx_hold = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic [127:0] gcd_mag(input logic [127:0] a, input logic [127:0] b);
      logic [127:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic bit fits_word(input logic signed [127:0] x);
      return (x >= -128'sd2147483648) && (x <= 128'sd2147483647);
   endfunction

   function automatic status_type reduce_fraction(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
      logic [127:0]        an, ad, g;
      logic signed [127:0] rn, rd;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      g = gcd_mag(an, ad);
      if (g == 0) g = 1;
      rn = $signed(an / g);
      rd = $signed(ad / g);
      if (num < 0) rn = -rn;
      if (den < 0) rd = -rd;
      if (!fits_word(rn) || !fits_word(rd)) return STATUS_OVERFLOW;
      acc_num = rn[31:0];
      acc_den = rd[31:0];
      return STATUS_OK;
   endfunction

   function automatic rsp_type predict_fraction(input req_type r);
      logic signed [127:0] na, da, nb, db, num, den;
      status_type          st;
      rsp_type             o;
      func_type            f;
      na = acc_num;
      da = acc_den;
      nb = $signed(r.operand_numerator);
      db = $signed(r.operand_denominator);
      f = func_type'(r.func);
      st = STATUS_OK;
      case (f)
         FUNC_LOAD: begin
            acc_num = r.operand_numerator;
            if (db == 0) begin
               acc_den = 32'sd1;
               st = STATUS_LOAD_ZERO;
            end else begin
               acc_den = r.operand_denominator;
            end
         end
         FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
            if (db == 0 || (f == FUNC_DIV && nb == 0)) begin
               st = STATUS_DIV_ZERO;
            end else begin
               case (f)
                  FUNC_ADD: begin num = na * db + nb * da; den = da * db; end
                  FUNC_SUB: begin num = na * db - nb * da; den = da * db; end
                  FUNC_MUL: begin num = na * nb; den = da * db; end
                  default:  begin num = na * db; den = da * nb; end
               endcase
               st = reduce_fraction(num, den);
            end
         end
         FUNC_INC: begin
            num = na + da;
            if (fits_word(num)) acc_num = num[31:0];
            else st = STATUS_OVERFLOW;
         end
         FUNC_REDUCE: st = reduce_fraction(na, da);
         default: st = STATUS_OK;
      endcase
      o.result_numerator = acc_num;
      o.result_denominator = acc_den;
      o.status = st;
      return o;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3: return 32'($signed($urandom_range(40)) - 20);
         4, 5:       return 32'($signed($urandom_range(2000)) - 1000);
         6:          return 32'($signed($urandom_range(200000)) - 100000);
         7, 8:       return $urandom;
         default: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               3: return 32'd1;
               default: return 32'd0;
            endcase
         end
      endcase
   endfunction

   task automatic send_item(input req_type r, input bit known, input rsp_type want);
      rsp_type pred;
      if (sent_count == 200) begin
         req_valid <= 1'b0;
         wait (pending_fractions.size() == 0);
         @(posedge clock);
      end
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pred = predict_fraction(r);
      pending_fractions.push_back(known ? want : pred);
      sent_count++;
      if (sent_count == 140) begin tx_idle_pct = 50; rx_idle_pct = 15; end
      if (sent_count == 280) begin tx_idle_pct = 0; rx_idle_pct = 0; end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_fractions.size() == 0) begin
               report_mismatch("response transfer with nothing expected");
            end else begin
               rsp_type e;
               e = pending_fractions.pop_front();
               if (rsp_data.result_numerator !== e.result_numerator)
                  report_mismatch($sformatf("numerator %h want %h",
                     rsp_data.result_numerator, e.result_numerator));
               if (rsp_data.result_denominator !== e.result_denominator)
                  report_mismatch($sformatf("denominator %h want %h",
                     rsp_data.result_denominator, e.result_denominator));
               if (rsp_data.status !== e.status)
                  report_mismatch($sformatf("status %0d want %0d",
                     rsp_data.status, e.status));
            end
         end
         rsp_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      wait (sent_count >= 60);
      rx_hold = 1'b1;
      repeat (400) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      req_type r;
      rows = '{
         '{FUNC_REDUCE, 32'd0, 32'd0, 1, '{32'd0, 32'd1, STATUS_OK}},
         '{FUNC_LOAD, 32'd7, 32'd0, 1, '{32'd7, 32'd1, STATUS_LOAD_ZERO}},
         '{FUNC_LOAD, 32'd6, 32'd4, 1, '{32'd6, 32'd4, STATUS_OK}},
         '{FUNC_REDUCE, 32'd0, 32'd0, 1, '{32'd3, 32'd2, STATUS_OK}},
         '{FUNC_DIV, 32'd0, 32'd5, 1, '{32'd3, 32'd2, STATUS_DIV_ZERO}},
         '{FUNC_ADD, 32'd1, 32'd0, 1, '{32'd3, 32'd2, STATUS_DIV_ZERO}},
         '{FUNC_ADD, 32'd1, 32'd2, 0, '0},
         '{FUNC_SUB, 32'd5, 32'd3, 0, '0},
         '{FUNC_MUL, -32'sd3, 32'd7, 0, '0},
         '{FUNC_DIV, 32'd2, -32'sd5, 0, '0},
         '{FUNC_INC, 32'd0, 32'd0, 0, '0},
         '{FUNC_NOP, 32'hffff_ffff, 32'hffff_ffff, 0, '0},
         '{FUNC_LOAD, 32'h7fff_ffff, 32'd1, 1, '{32'h7fff_ffff, 32'd1, STATUS_OK}},
         '{FUNC_INC, 32'd0, 32'd0, 1, '{32'h7fff_ffff, 32'd1, STATUS_OVERFLOW}},
         '{FUNC_MUL, 32'd2, 32'd1, 1, '{32'h7fff_ffff, 32'd1, STATUS_OVERFLOW}},
         '{FUNC_LOAD, 32'h8000_0000, 32'h8000_0000, 1,
           '{32'h8000_0000, 32'h8000_0000, STATUS_OK}},
         '{FUNC_REDUCE, 32'd0, 32'd0, 1, '{32'hffff_ffff, 32'hffff_ffff, STATUS_OK}},
         '{FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0},
         '{FUNC_LOAD, 32'd0, -32'sd3, 1, '{32'd0, 32'hffff_fffd, STATUS_OK}},
         '{FUNC_REDUCE, 32'd0, 32'd0, 1, '{32'd0, 32'hffff_ffff, STATUS_OK}},
         '{FUNC_LOAD, 32'h8000_0000, 32'd1, 1, '{32'h8000_0000, 32'd1, STATUS_OK}},
         '{FUNC_DIV, 32'hffff_ffff, 32'd1, 0, '0},
         '{FUNC_SUB, 32'h7fff_ffff, 32'd1, 0, '0}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         r.func = rows[i].func;
         r.operand_numerator = rows[i].num;
         r.operand_denominator = rows[i].den;
         send_item(r, rows[i].known, rows[i].want);
      end
      repeat (400) begin
         r.func = ($urandom_range(99) < 18) ? FUNC_LOAD : 3'($urandom_range(7));
         r.operand_numerator = pick_value();
         r.operand_denominator = pick_value();
         send_item(r, 1'b0, '0);
      end
      req_valid <= 1'b0;
      wait (pending_fractions.size() == 0);
      repeat (600) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
